### rtl/udphc_pkg.sv
// udphc_pkg: shared types, constants and the one's-complement adder for the
// udp header check block. No dependencies; imported by every rtl module.
`default_nettype none

package udphc_pkg;

    // header and pseudo-header sizes
    localparam int unsigned HEADER_BYTES = 8;
    localparam logic [5:0]  ADDR_LIMIT_V4 = 6'd8;
    localparam logic [5:0]  ADDR_LIMIT_V6 = 6'd32;
    localparam logic [15:0] UDP_PROTOCOL = 16'd17;
    localparam logic [15:0] SUM_GOOD = 16'hFFFF;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SHORT    = 2'd1,
        ST_LEN_ERR  = 2'd2,
        ST_CSUM_ERR = 2'd3
    } status_t;

    // packet state handed to the judging stage on the last item
    typedef struct packed {
        logic [15:0] sum;
        logic [16:0] count;
        logic [15:0] length;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] csum;
    } snap_t;

    // one's-complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

### rtl/udphc_accum.sv
// udphc_accum: input register, running one's-complement sum, byte counters
// and header field capture. Depends on udphc_pkg.
`default_nettype none

module udphc_accum
    import udphc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,     // [0] is_address, [1] is_ipv6
    input  wire logic        s_tlast,
    output logic             snap_valid,
    input  wire logic        snap_ready,
    output snap_t            snap
);

    // input register
    logic        a_vld_reg;
    logic [7:0]  a_byte_reg;
    logic        a_addr_reg;
    logic        a_v6_reg;
    logic        a_last_reg;

    // packet state
    logic [15:0] sum_reg,    sum_next;
    logic [7:0]  held_reg,   held_next;
    logic        phase_reg,  phase_next;
    logic [16:0] count_reg,  count_next;
    logic [5:0]  addr_reg,   addr_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] src_reg,    src_next;
    logic [15:0] dst_reg,    dst_next;
    logic [15:0] csum_reg,   csum_next;

    logic        a_adv;
    logic        take;
    logic [5:0]  limit;
    logic        word_en;
    logic [15:0] word;

    assign snap_valid = a_vld_reg && a_last_reg;
    assign a_adv      = a_vld_reg && (!a_last_reg || snap_ready);
    assign s_tready   = !a_vld_reg || a_adv;

    // next packet state for the item in the input register
    always_comb begin
        limit = a_v6_reg ? ADDR_LIMIT_V6 : ADDR_LIMIT_V4;
        take  = a_addr_reg ? (addr_reg < limit) : 1'b1;

        // pair bytes into words; on the last item a waiting byte pairs with zero
        word_en = 1'b0;
        word    = 16'd0;
        if (take && phase_reg) begin
            word_en = 1'b1;
            word    = {held_reg, a_byte_reg};
        end else if (take && a_last_reg) begin
            word_en = 1'b1;
            word    = {a_byte_reg, 8'd0};
        end else if (phase_reg && a_last_reg) begin
            word_en = 1'b1;
            word    = {held_reg, 8'd0};
        end
        sum_next   = word_en ? ones_add(sum_reg, word) : sum_reg;
        held_next  = (take && !phase_reg) ? a_byte_reg : held_reg;
        phase_next = take ? !phase_reg : phase_reg;

        // counters, segment count saturates at 65536
        count_next = (!a_addr_reg && !count_reg[16]) ? count_reg + 17'd1 : count_reg;
        addr_next  = (a_addr_reg && take) ? addr_reg + 6'd1 : addr_reg;

        // header field capture from segment bytes 0..7
        length_next = length_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        csum_next   = csum_reg;
        if (!a_addr_reg && count_reg < 17'(HEADER_BYTES)) begin
            case (count_reg[2:0])
                3'd0:    src_next    = {a_byte_reg, 8'd0};
                3'd1:    src_next    = {src_reg[15:8], a_byte_reg};
                3'd2:    dst_next    = {a_byte_reg, 8'd0};
                3'd3:    dst_next    = {dst_reg[15:8], a_byte_reg};
                3'd4:    length_next = {a_byte_reg, 8'd0};
                3'd5:    length_next = {length_reg[15:8], a_byte_reg};
                3'd6:    csum_next   = {a_byte_reg, 8'd0};
                default: csum_next   = {csum_reg[15:8], a_byte_reg};
            endcase
        end

        snap.sum    = sum_next;
        snap.count  = count_next;
        snap.length = length_next;
        snap.src    = src_next;
        snap.dst    = dst_next;
        snap.csum   = csum_next;
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (s_tready) begin
            a_vld_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_byte_reg <= s_tdata;
            a_addr_reg <= s_tuser[0];
            a_v6_reg   <= s_tuser[1];
            a_last_reg <= s_tlast;
        end
    end

    // packet state, cleared after the last item
    always_ff @(posedge aclk) begin
        if (!aresetn || (a_adv && a_last_reg)) begin
            sum_reg    <= '0;
            held_reg   <= '0;
            phase_reg  <= 1'b0;
            count_reg  <= '0;
            addr_reg   <= '0;
            length_reg <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            csum_reg   <= '0;
        end else if (a_adv) begin
            sum_reg    <= sum_next;
            held_reg   <= held_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            length_reg <= length_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            csum_reg   <= csum_next;
        end
    end

    // a finished packet leaves the state empty
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        a_adv && a_last_reg |=> count_reg == 17'd0 && !phase_reg && addr_reg == 6'd0)
        else $error("packet state not cleared after last item");

    // address bytes never exceed the ipv6 pseudo-header size
    a_addr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_reg <= ADDR_LIMIT_V6)
        else $error("address byte count beyond limit");

endmodule

`default_nettype wire

### rtl/udphc_judge.sv
// udphc_judge: end-of-packet register, pseudo-header completion, judgement
// and the result output register. Depends on udphc_pkg.
`default_nettype none

module udphc_judge
    import udphc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        snap_valid,
    output logic             snap_ready,
    input  wire snap_t       snap,
    input  wire logic        csum_en,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] source_port, [31:16] dest_port,
                                        // [47:32] payload_length
    output logic [2:0]       m_tuser    // [1:0] status, [2] checksum_checked
);

    logic        c_vld_reg;
    snap_t       c_reg;
    logic        m_vld_reg;
    logic [47:0] m_data_reg, m_data_next;
    logic [2:0]  m_user_reg, m_user_next;

    logic        c_go;
    logic [17:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        verify;
    status_t     status;

    assign c_go       = c_vld_reg && (!m_vld_reg || m_tready);
    assign snap_ready = !c_vld_reg || c_go;
    assign m_tvalid   = m_vld_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_user_reg;

    // add protocol and received length, then judge
    always_comb begin
        total  = {2'd0, c_reg.sum} + {2'd0, UDP_PROTOCOL} + {2'd0, c_reg.count[15:0]};
        fold1  = {1'b0, total[15:0]} + {15'd0, total[17:16]};
        fold2  = fold1[15:0] + {15'd0, fold1[16]};
        verify = 1'b0;
        m_data_next = '0;
        if (c_reg.count < 17'(HEADER_BYTES)) begin
            status = ST_SHORT;
        end else if (c_reg.count[16] || {1'b0, c_reg.length} > c_reg.count ||
                     c_reg.length < 16'(HEADER_BYTES)) begin
            status = ST_LEN_ERR;
        end else begin
            verify = csum_en && (c_reg.csum != 16'd0);
            if (verify && fold2 != SUM_GOOD) begin
                status = ST_CSUM_ERR;
            end else begin
                status = ST_OK;
                m_data_next = {c_reg.length - 16'(HEADER_BYTES), c_reg.dst, c_reg.src};
            end
        end
        m_user_next = {verify, status};
    end

    // end-of-packet register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (snap_ready) begin
            c_vld_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            c_reg <= snap;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (!m_vld_reg || m_tready) begin
            m_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_go) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    // fields other than status are zero on a failed packet
    j_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && m_user_reg[1:0] != ST_OK |-> m_data_reg == 48'd0)
        else $error("result fields set on failed packet");

    // checksum only marked checked for ok or checksum error
    j_checked_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && m_user_reg[2] |-> m_user_reg[1:0] == ST_OK ||
            m_user_reg[1:0] == ST_CSUM_ERR)
        else $error("checked flag with wrong status");

    // a waiting end-of-packet entry is not dropped
    j_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        c_vld_reg && !c_go |=> c_vld_reg)
        else $error("pending packet lost");

    // ok results carry a payload length within range
    j_plen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && m_user_reg[1:0] == ST_OK |-> m_data_reg[47:32] <= 16'd65527)
        else $error("payload length out of range");

endmodule

`default_nettype wire

### rtl/udp_header_check_and_strip.sv
// udp_header_check_and_strip: top level, configuration register and the two
// pipeline parts. Depends on udphc_pkg, udphc_accum and udphc_judge.
//
// Usage:
//   s_ channel carries one byte per item: pseudo-header address bytes
//   (source then destination) followed by the udp segment bytes, s_tlast on
//   the final byte. s_tuser[0] marks an address byte, s_tuser[1] an ipv6
//   packet. One result item leaves on m_ for each packet, after its last
//   byte: status and checked flag in m_tuser, ports and payload length in
//   m_tdata (zero unless the status is ok).
//   cfg_valid/cfg_data write checksum_enable; cfg_ready is always high.
// Throughput: one byte per cycle while m_tready is high, with no gaps between packets.
// Path: after the last byte is accepted, the result passes through the input
//   register, then the end-of-packet register, then the result register.
// Reset: aresetn low clears the packet state, empties the pipeline and sets
//   checksum_enable to 1.
// Stall: when m_tready is low the result holds; the block keeps taking bytes
//   until the end-of-packet register and input register fill, then drops
//   s_tready.
`default_nettype none

module udp_header_check_and_strip
    import udphc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [0] is_address, [1] is_ipv6
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] source_port, [31:16] dest_port,
                                        // [47:32] payload_length
    output logic [2:0]       m_tuser,   // [1:0] status, [2] checksum_checked
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // checksum_enable
);

    logic  csum_en_reg;
    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    assign cfg_ready = 1'b1;

    // checksum enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csum_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            csum_en_reg <= cfg_data;
        end
    end

    udphc_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    udphc_judge u_judge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .csum_en    (csum_en_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
